// File: rtl/i2c_target_register_file_unit_assert.svh
// Assertion macros for the I2C target register file unit.
`ifndef I2C_TARGET_REGISTER_FILE_UNIT_ASSERT_SVH
`define I2C_TARGET_REGISTER_FILE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define I2CTRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define I2CTRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CTRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define I2CTRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/i2ctrf_pkg.sv
// Shared types and constants of the I2C target register file.
package i2ctrf_pkg;

  localparam int STORE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PTR_LOAD = 2'd1,
    MODE_WRITE    = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Request from the sequencer to the store.
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  // One result word, before the output register.
  typedef struct packed {
    logic       strobe;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } result_t;

endpackage

// File: rtl/i2ctrf_store.sv
// Register store: synchronous memory with registered read and per-entry valid bits.
module i2ctrf_store
  import i2ctrf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [7:0]             mem_r [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [7:0]             rdata_r;
  logic                   rvalid_r;
  logic [AW-1:0]          idx;

  assign idx = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[idx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r  <= mem_r[idx];
      rvalid_r <= valid_r[idx];
    end
  end

  // never-written entries read as the reset value
  assign rdata = rvalid_r ? rdata_r : 8'd0;

endmodule

// File: rtl/i2ctrf_ctrl.sv
// Sequencer: access mode, register pointer and per-byte read or write of the store.
module i2ctrf_ctrl
  import i2ctrf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_is_address_byte,
  input  logic       in_read_not_write,
  input  logic [7:0] in_rx_byte,
  output mem_req_t   req,
  input  logic [7:0] rdata,
  output result_t    res
);

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] ptr_r, ptr_nxt;
  logic       is_addr_r;
  logic       rd_r;
  logic [7:0] byte_r;
  logic       accept;
  logic       in_range;
  logic [7:0] ptr_inc;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r == ST_EXEC);
  assign in_range = ({1'b0, ptr_r} < 9'(STORE_DEPTH));
  assign ptr_inc  = (ptr_r == 8'hFF) ? ptr_r : ptr_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_IDLE;
      ptr_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_addr_r <= in_is_address_byte;
      rd_r      <= in_read_not_write;
      byte_r    <= in_rx_byte;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    ptr_nxt      = ptr_r;
    req.rd_en    = 1'b0;
    req.wr_en    = 1'b0;
    req.addr     = ptr_r;
    req.wdata    = byte_r;
    res.strobe   = 1'b0;
    res.tx_valid = 1'b0;
    res.tx_byte  = 8'd0;
    unique case (state_r)
      ST_IDLE: begin
        // fetch the entry at the pointer while the word is captured
        if (accept) begin
          req.rd_en = in_range;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res.strobe = 1'b1;
        state_nxt  = ST_IDLE;
        if (is_addr_r) begin
          mode_nxt = rd_r ? MODE_READ : MODE_PTR_LOAD;
        end else begin
          unique case (mode_r)
            MODE_PTR_LOAD: begin
              ptr_nxt  = byte_r;
              mode_nxt = MODE_WRITE;
            end
            MODE_WRITE: begin
              req.wr_en = in_range;
              ptr_nxt   = ptr_inc;
            end
            MODE_READ: begin
              res.tx_valid = 1'b1;
              res.tx_byte  = in_range ? rdata : 8'd0;
              ptr_nxt      = ptr_inc;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/i2c_target_register_file_unit.sv
// A word is accepted in the idle state and runs in the execute state; its result
// is registered in the output register before it shows on the out_ ports.
// No new word is taken while busy: each word needs the read of the store at accept
// followed by the execute state that writes back and updates the pointer.
// busy is high during the execute state; the output register frees the input side.
// Reset (synchronous, rst_n low): mode idle, pointer 0, all store entries read as 0.
// Results cannot be stalled: each lasts one cycle, marked by out_strobe.
`include "i2c_target_register_file_unit_assert.svh"

module i2c_target_register_file_unit
  import i2ctrf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_is_address_byte,
  input  logic       in_read_not_write,
  input  logic [7:0] in_rx_byte,
  output logic       out_strobe,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte
);

  mem_req_t   req;
  logic [7:0] rdata;
  result_t    res;

  logic       strobe_r;
  logic       tx_valid_r;
  logic [7:0] tx_byte_r;

  // Sequencer: holds mode and pointer, issues the store read at accept
  // and the write-back in the execute state.
  i2ctrf_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_is_address_byte(in_is_address_byte),
    .in_read_not_write (in_read_not_write),
    .in_rx_byte        (in_rx_byte),
    .req               (req),
    .rdata             (rdata),
    .res               (res)
  );

  // Register store; write of one word and read of the next never overlap,
  // since a read is issued only at accept, in the idle state, and a write only in the execute state.
  i2ctrf_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rdata(rdata)
  );

  // Output register: the result word shows for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r   <= 1'b0;
      tx_valid_r <= 1'b0;
    end else begin
      strobe_r   <= res.strobe;
      tx_valid_r <= res.tx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.strobe) begin
      tx_byte_r <= res.tx_byte;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_tx_valid = tx_valid_r;
  assign out_tx_byte  = tx_byte_r;

  // every accepted word enters the execute cycle
  `I2CTRF_ASSERT_NXT(a_accept_exec, clk, rst_n, start && !busy, busy, "accept without exec")
  // every execute cycle yields exactly one result word
  `I2CTRF_ASSERT_NXT(a_exec_result, clk, rst_n, busy, out_strobe && !busy, "exec without result")
  // tx_valid only on a result word
  `I2CTRF_ASSERT_IMP(a_valid_strobe, clk, rst_n, out_tx_valid, out_strobe, "tx_valid without strobe")
  // a result that carries no byte has a zero byte
  `I2CTRF_ASSERT_IMP(a_zero_byte, clk, rst_n, out_strobe && !out_tx_valid, out_tx_byte == 8'd0,
    "nonzero byte without tx_valid")

endmodule

// File: sim/i2c_target_register_file_unit_tb.sv
// Self-checking testbench for the I2C target register file unit.

// Predicts each tx word from a private copy of mode, pointer and store.
class reg_file_scoreboard;
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
  } tx_word_t;

  i2ctrf_pkg::mode_t mode;
  logic [7:0]        ptr;
  logic [7:0]        regs [i2ctrf_pkg::STORE_DEPTH_DEF];
  tx_word_t          pending_tx [$];
  int                errors;

  function new();
    mode   = i2ctrf_pkg::MODE_IDLE;
    ptr    = 8'd0;
    errors = 0;
    foreach (regs[i]) regs[i] = 8'd0;
  endfunction

  function void note_word(logic is_addr, logic rnw, logic [7:0] rx);
    tx_word_t w;
    w = '0;
    if (is_addr) begin
      mode = rnw ? i2ctrf_pkg::MODE_READ : i2ctrf_pkg::MODE_PTR_LOAD;
    end else begin
      case (mode)
        i2ctrf_pkg::MODE_PTR_LOAD: begin
          ptr  = rx;
          mode = i2ctrf_pkg::MODE_WRITE;
        end
        i2ctrf_pkg::MODE_WRITE: begin
          if (ptr < i2ctrf_pkg::STORE_DEPTH_DEF) regs[ptr] = rx;
          if (ptr != 8'hFF) ptr++;
        end
        i2ctrf_pkg::MODE_READ: begin
          w.tx_valid = 1'b1;
          if (ptr < i2ctrf_pkg::STORE_DEPTH_DEF) w.tx_byte = regs[ptr];
          if (ptr != 8'hFF) ptr++;
        end
        default: ;
      endcase
    end
    pending_tx.push_back(w);
  endfunction

  function void check_tx(logic tx_valid, logic [7:0] tx_byte);
    tx_word_t exp_w;
    if (pending_tx.size() == 0) begin
      errors++;
      $display("%0t: unexpected tx word: expected none, got valid=%b byte=%02h",
               $time, tx_valid, tx_byte);
    end else begin
      exp_w = pending_tx.pop_front();
      if (tx_valid !== exp_w.tx_valid) begin
        errors++;
        $display("%0t: tx_valid mismatch: expected %b, got %b",
                 $time, exp_w.tx_valid, tx_valid);
      end
      if (tx_byte !== exp_w.tx_byte) begin
        errors++;
        $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                 $time, exp_w.tx_byte, tx_byte);
      end
    end
  endfunction
endclass

module i2c_target_register_file_unit_tb;
  import i2ctrf_pkg::*;

  // Roughly 25 directed words, the rest random transactions.
  localparam int RANDOM_WORDS   = 725;
  // Cycles with neither an accepted word nor a result before giving up.
  // A correct run stays far below the limit: the longest quiet stretch is
  // the sender gap plus the block latency.
  localparam int WATCHDOG_LIMIT = 500;
  // Settle time at the end, well beyond the block latency.
  localparam int DRAIN_CYCLES   = 8;

  logic       clk;
  logic       rst_n              = 1'b0;
  logic       start              = 1'b0;
  logic       busy;
  logic       in_is_address_byte = 1'b0;
  logic       in_read_not_write  = 1'b0;
  logic [7:0] in_rx_byte         = 8'd0;
  logic       out_strobe;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;

  reg_file_scoreboard sb = new();

  int unsigned words_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          no_idle      = 1'b0;

  i2c_target_register_file_unit #(
    .STORE_DEPTH(STORE_DEPTH_DEF)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_is_address_byte(in_is_address_byte),
    .in_read_not_write (in_read_not_write),
    .in_rx_byte        (in_rx_byte),
    .out_strobe        (out_strobe),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor and watchdog. Everything here reads pre-edge values: the block's
  // flops and the driver both update through nonblocking assignments.
  // An accepted word is noted before a result is checked; the result of a
  // word never shows up at its own accept edge, so the order is harmless.
  always @(posedge clk) begin
    bit progress;
    progress = 1'b0;
    if (rst_n && start && !busy) begin
      sb.note_word(in_is_address_byte, in_read_not_write, in_rx_byte);
      progress = 1'b1;
    end
    if (rst_n && out_strobe) begin
      sb.check_tx(out_tx_valid, out_tx_byte);
      progress = 1'b1;
    end
    if (progress) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d tx words outstanding",
               $time, sb.pending_tx.size());
      $display("i2c_target_register_file_unit_tb: FAIL");
      $finish;
    end
  end

  // Drive one word. Called right after a rising edge; returns right after
  // the edge that accepted the word, so back-to-back calls with no gap keep start
  // high without dropping it. busy is looked at on the falling edge, where it is
  // settled and equals what the next rising edge will see.
  task automatic send_word(logic is_addr, logic rnw, logic [7:0] rx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_is_address_byte <= is_addr;
    in_read_not_write  <= rnw;
    in_rx_byte         <= rx;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Hold off the sender until every predicted tx word has come out.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending_tx.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Pointer values: mostly around the store edge, some near saturation,
  // some anywhere.
  function automatic logic [7:0] rand_pointer();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return 8'($urandom_range(0, STORE_DEPTH_DEF + 1));
      5:             return 8'($urandom_range(250, 255));
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned burst;
    bit          drained;

    drained = 1'b0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed part ----
    // Data while idle must be ignored (no store write, tx_valid low).
    send_word(1'b0, 1'b0, 8'h5A);
    // Write address; rx_byte of an address word is ignored.
    send_word(1'b1, 1'b0, 8'hFF);
    // Pointer load to 0, then three writes with the byte extremes.
    send_word(1'b0, 1'b0, 8'h00);
    send_word(1'b0, 1'b0, 8'hFF);
    send_word(1'b0, 1'b1, 8'h00);
    send_word(1'b0, 1'b0, 8'hA5);
    // Last entry of the store, then a write past the end that is dropped.
    send_word(1'b1, 1'b0, 8'h00);
    send_word(1'b0, 1'b0, 8'(STORE_DEPTH_DEF - 1));
    send_word(1'b0, 1'b0, 8'h3C);
    send_word(1'b0, 1'b0, 8'h77);
    // Read with the pointer out of range returns zero.
    send_word(1'b1, 1'b1, 8'h00);
    send_word(1'b0, 1'b1, 8'hFF);
    // Pointer near the top: it has to stick at 255 on writes and reads.
    send_word(1'b1, 1'b0, 8'h81);
    send_word(1'b0, 1'b0, 8'hFE);
    send_word(1'b0, 1'b0, 8'h11);
    send_word(1'b0, 1'b0, 8'h22);
    send_word(1'b1, 1'b1, 8'hFF);
    send_word(1'b0, 1'b0, 8'h00);
    send_word(1'b0, 1'b1, 8'h33);
    // Rewind to 0 and read back what was written at the start.
    send_word(1'b1, 1'b0, 8'h00);
    send_word(1'b0, 1'b1, 8'h00);
    send_word(1'b1, 1'b1, 8'h7E);
    send_word(1'b0, 1'b0, 8'h00);
    send_word(1'b0, 1'b1, 8'hFF);
    send_word(1'b0, 1'b0, 8'h55);

    // ---- Random part ----
    // Mostly well-formed bus transactions with random content; about one
    // in five is loose noise that may hit any mode.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 9);
      burst   = $urandom_range(1, 6);
      if (kind <= 3) begin
        // Write transaction: address, pointer, data burst.
        send_word(1'b1, 1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b0, 1'($urandom_range(0, 1)), rand_pointer());
        repeat (burst)
          send_word(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (kind <= 7) begin
        // Read transaction, half the time after setting the pointer (repeated start).
        if (kind <= 5) begin
          send_word(1'b1, 1'b0, 8'($urandom_range(0, 255)));
          send_word(1'b0, 1'($urandom_range(0, 1)), rand_pointer());
        end
        send_word(1'b1, 1'b1, 8'($urandom_range(0, 255)));
        repeat (burst)
          send_word(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
      end
      // Once midway, let the pipeline run dry before going on.
      if (!drained && words_sent >= RANDOM_WORDS / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end

    // ---- End of run ----
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_tx.size() != 0)
      $display("%0t: %0d tx words never arrived", $time, sb.pending_tx.size());
    if (sb.errors == 0 && sb.pending_tx.size() == 0) begin
      $display("i2c_target_register_file_unit_tb: PASS");
    end else begin
      $display("i2c_target_register_file_unit_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: i2c_target_register_file_unit.f
+incdir+rtl
rtl/i2ctrf_pkg.sv
rtl/i2ctrf_store.sv
rtl/i2ctrf_ctrl.sv
rtl/i2c_target_register_file_unit.sv
sim/i2c_target_register_file_unit_tb.sv
